### hw/rtl/mvn_pkg.sv
// mvn_pkg: shared constants, codes and sequencer states for mesh_vertex_normals
// no dependencies
package mvn_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int IDX_W        = 17;   // holds any depth in range for index reduction

  localparam int POS_W  = 16;
  localparam int SUM_W  = 24;
  localparam int VEC_W  = 35;         // cross product magnitude stays below 2^34
  localparam int MAG_W  = 30;         // normalized magnitude width
  localparam int MUL_W  = 31;
  localparam int LEN_W  = 31;
  localparam int QUO_W  = 15;

  localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
  localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_TRI   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_LOAD,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_RDLAST,
    ST_CROSS,
    ST_QRD,
    ST_QWAIT,
    ST_ABS,
    ST_SHIFT,
    ST_SQUARE,
    ST_SQRT,
    ST_DIVINIT,
    ST_DIV,
    ST_ACCRD,
    ST_ACCWR,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/mesh_vertex_normals.sv
// mesh_vertex_normals: vertex position and normal sum tables with one shared
// multiplier, a bit-serial square root and a restoring divider; uses mvn_pkg
//
// channel   signals                                  handshake
// command   func vertex_index pos_* corner_*         start & !busy
// result    result_kind norm_* degenerate            done, one cycle
//
// the square root runs 32 steps and each of the three divisions 15 steps.
// after reset a clearing pass writes zero to all VERTEX_DEPTH entries of the
// sum table with busy high. the receiver cannot stall: each result shows for
// one cycle.
module mesh_vertex_normals
  import mvn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic [9:0]               vertex_index,
  input  logic signed [15:0]       pos_x,
  input  logic signed [15:0]       pos_y,
  input  logic signed [15:0]       pos_z,
  input  logic [9:0]               corner_a,
  input  logic [9:0]               corner_b,
  input  logic [9:0]               corner_c,
  output logic                     done,
  output logic                     result_kind,
  output logic signed [15:0]       norm_x,
  output logic signed [15:0]       norm_y,
  output logic signed [15:0]       norm_z,
  output logic                     degenerate
);

  state_t state, state_next;

  // memories
  logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_DEPTH];
  logic [3*POS_W-1:0] pos_q;
  logic [3*SUM_W-1:0] sum_q;
  logic [ADDR_W-1:0]  pos_addr, sum_addr;
  logic               pos_we, sum_we;
  logic [3*SUM_W-1:0] sum_wdata;

  logic [ADDR_W-1:0]  clr_cnt;
  func_t              op;
  logic [IDX_W-1:0]   ridx [3];
  logic [3*POS_W-1:0] pa, pb, pc;
  logic [3*POS_W-1:0] pload;
  logic [5:0]         step;
  logic [1:0]         comp;

  logic signed [VEC_W-1:0] vec [3];
  logic [VEC_W-1:0]        mag [3];
  logic                    neg [3];
  logic [VEC_W-1:0]        mmax;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [63:0]        acc;

  logic [63:0] sq_rem, sq_res, sq_bit;
  logic [63:0] sq_try;
  logic [LEN_W-1:0] len;

  logic [LEN_W-1:0] drem;
  logic [QUO_W-1:0] nbits, quo, quo_next;
  logic [LEN_W:0]   dtry;
  logic [44:0]      dnum;

  logic signed [POS_W-1:0] nout [3];

  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];

  logic idx_big;

  function automatic logic signed [POS_W-1:0] pos_comp(input logic [3*POS_W-1:0] w,
                                                       input int i);
    pos_comp = w[(2-i)*POS_W +: POS_W];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic signed [POS_W-1:0] n);
    logic signed [SUM_W:0] t;
    t = $signed({s[SUM_W-1], s}) + (SUM_W+1)'(n);
    if (t > SUM_MAX) t = SUM_MAX;
    if (t < SUM_MIN) t = SUM_MIN;
    sat_add = t[SUM_W-1:0];
  endfunction

  assign busy = (state != ST_IDLE);
  assign norm_x = nout[0];
  assign norm_y = nout[1];
  assign norm_z = nout[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 17'(pos_comp(pb, i)) - 17'(pos_comp(pa, i));
      e2[i] = 17'(pos_comp(pc, i)) - 17'(pos_comp(pb, i));
    end
  end

  always_comb begin
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
  end

  always_comb begin
    idx_big = 1'b0;
    for (int i = 0; i < 3; i++)
      if (ridx[i] >= IDX_W'(VERTEX_DEPTH)) idx_big = 1'b1;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_CROSS) begin
      case (step)
        6'd0: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[2]); end
        6'd1: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[1]); end
        6'd2: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[0]); end
        6'd3: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[2]); end
        6'd4: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[1]); end
        6'd5: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[0]); end
        default: ;
      endcase
    end else if (state == ST_SQUARE && step < 6'd3) begin
      mul_a = $signed({1'b0, mag[step[1:0]][MAG_W-1:0]});
      mul_b = mul_a;
    end
  end

  assign sq_try   = sq_res + sq_bit;
  assign dtry     = {drem, nbits[QUO_W-1]};
  assign quo_next = {quo[QUO_W-2:0], (dtry >= {1'b0, len})};
  assign dnum     = {1'b0, mag[comp][MAG_W-1:0], 14'b0} + 45'(len >> 1);

  // next state and memory controls
  always_comb begin
    state_next = state;
    pos_addr   = ADDR_W'(ridx[0]);
    sum_addr   = ADDR_W'(ridx[0]);
    pos_we     = 1'b0;
    sum_we     = 1'b0;
    sum_wdata  = '0;
    case (state)
      ST_CLEAR: begin
        sum_addr = clr_cnt;
        sum_we   = 1'b1;
        if (clr_cnt == ADDR_W'(VERTEX_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && func_t'(func) != FUNC_NONE) state_next = ST_INDEX;
      end
      ST_INDEX: begin
        if (!idx_big) begin
          case (op)
            FUNC_LOAD: state_next = ST_LOAD;
            FUNC_TRI:  state_next = ST_RDA;
            default:   state_next = ST_QRD;
          endcase
        end
      end
      ST_LOAD: begin
        pos_we     = 1'b1;
        sum_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RDA:    state_next = ST_RDB;
      ST_RDB: begin
        pos_addr   = ADDR_W'(ridx[1]);
        state_next = ST_RDC;
      end
      ST_RDC: begin
        pos_addr   = ADDR_W'(ridx[2]);
        state_next = ST_RDLAST;
      end
      ST_RDLAST: state_next = ST_CROSS;
      ST_CROSS:  if (step == 6'd6) state_next = ST_ABS;
      ST_QRD:    state_next = ST_QWAIT;
      ST_QWAIT:  state_next = ST_ABS;
      ST_ABS:    state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (mmax == '0) state_next = ST_EMIT;
        else if (mmax[VEC_W-1:MAG_W] == '0 && mmax[MAG_W-1]) state_next = ST_SQUARE;
      end
      ST_SQUARE: if (step == 6'd3) state_next = ST_SQRT;
      ST_SQRT:   if (step == 6'd31) state_next = ST_DIVINIT;
      ST_DIVINIT: state_next = ST_DIV;
      ST_DIV: begin
        if (step == 6'(QUO_W - 1)) begin
          if (comp != 2'd2) state_next = ST_DIVINIT;
          else if (op == FUNC_TRI) state_next = ST_ACCRD;
          else state_next = ST_EMIT;
        end
      end
      ST_ACCRD: begin
        sum_addr   = ADDR_W'(ridx[comp]);
        state_next = ST_ACCWR;
      end
      ST_ACCWR: begin
        sum_addr  = ADDR_W'(ridx[comp]);
        sum_we    = 1'b1;
        sum_wdata = {sat_add(sum_q[2*SUM_W +: SUM_W], nout[0]),
                     sat_add(sum_q[SUM_W +: SUM_W], nout[1]),
                     sat_add(sum_q[0 +: SUM_W], nout[2])};
        state_next = (comp == 2'd2) ? ST_EMIT : ST_ACCRD;
      end
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= pload;
    pos_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_q <= sum_mem[sum_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      done <= (state == ST_EMIT);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          op          <= func_t'(func);
          ridx[0]     <= IDX_W'((func_t'(func) == FUNC_TRI) ? corner_a : vertex_index);
          ridx[1]     <= IDX_W'(corner_b);
          ridx[2]     <= IDX_W'(corner_c);
          pload       <= {pos_x, pos_y, pos_z};
          degenerate  <= 1'b0;
          result_kind <= (func_t'(func) == FUNC_QUERY);
        end
      end
      ST_INDEX: begin
        for (int i = 0; i < 3; i++)
          if (ridx[i] >= IDX_W'(VERTEX_DEPTH)) ridx[i] <= ridx[i] - IDX_W'(VERTEX_DEPTH);
        step <= '0;
      end
      ST_RDB:    pa <= pos_q;
      ST_RDC:    pb <= pos_q;
      ST_RDLAST: pc <= pos_q;
      ST_CROSS: begin
        prod <= mul_a * mul_b;
        step <= step + 1'b1;
        case (step)
          6'd1, 6'd3, 6'd5: acc <= 64'(prod);
          6'd2: vec[0] <= VEC_W'(acc - 64'(prod));
          6'd4: vec[1] <= VEC_W'(acc - 64'(prod));
          6'd6: vec[2] <= VEC_W'(acc - 64'(prod));
          default: ;
        endcase
      end
      ST_QWAIT: begin
        vec[0] <= VEC_W'($signed(sum_q[2*SUM_W +: SUM_W]));
        vec[1] <= VEC_W'($signed(sum_q[SUM_W +: SUM_W]));
        vec[2] <= VEC_W'($signed(sum_q[0 +: SUM_W]));
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vec[i][VEC_W-1];
          mag[i] <= vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
        end
      end
      ST_SHIFT: begin
        step <= '0;
        if (mmax == '0) begin
          degenerate <= 1'b1;
          for (int i = 0; i < 3; i++) nout[i] <= '0;
        end else if (mmax[VEC_W-1:MAG_W] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (mmax[MAG_W-1:MAG_W-4] == '0) begin
          // far below range: move four places at once
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 4;
        end else if (!mmax[MAG_W-1]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      ST_SQUARE: begin
        prod <= mul_a * mul_b;
        step <= (step == 6'd3) ? '0 : step + 1'b1;
        case (step)
          6'd1: acc <= 64'(prod);
          6'd2: acc <= acc + 64'(prod);
          6'd3: begin
            sq_rem <= 64'(acc + 64'(prod));
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
          end
          default: ;
        endcase
      end
      ST_SQRT: begin
        if (sq_rem >= sq_try) begin
          sq_rem <= sq_rem - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        step   <= step + 1'b1;
        if (step == 6'd31) begin
          len  <= (sq_rem >= sq_try) ? LEN_W'((sq_res >> 1) + sq_bit) : LEN_W'(sq_res >> 1);
          comp <= 2'd0;
        end
      end
      ST_DIVINIT: begin
        // quotient stays below 2^15, so the top part is already below len
        drem  <= LEN_W'(dnum >> QUO_W);
        nbits <= dnum[QUO_W-1:0];
        quo   <= '0;
        step  <= '0;
      end
      ST_DIV: begin
        drem  <= (dtry >= {1'b0, len}) ? LEN_W'(dtry - {1'b0, len}) : LEN_W'(dtry);
        nbits <= nbits << 1;
        quo   <= quo_next;
        step  <= step + 1'b1;
        if (step == 6'(QUO_W - 1)) begin
          nout[comp] <= neg[comp] ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
          comp <= (comp == 2'd2) ? 2'd0 : comp + 1'b1;
        end
      end
      ST_ACCWR: comp <= comp + 1'b1;
      default: ;
    endcase
  end

endmodule

### hw/rtl/mvn_checker.sv
// mvn_checker: port-level assertions for mesh_vertex_normals, bound to the top
// uses mvn_pkg for function codes
module mvn_checker
  import mvn_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         func,
  input logic               done,
  input logic signed [15:0] norm_x,
  input logic signed [15:0] norm_y,
  input logic signed [15:0] norm_z,
  input logic               degenerate
);

  // a result word never follows another directly
  a_single_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result words in a row");

  // an accepted word cannot produce a result in the next cycle
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too early after accept");

  a_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func != FUNC_NONE) |=> busy)
    else $error("command word accepted without going busy");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (norm_x == 16'sd0 && norm_y == 16'sd0 && norm_z == 16'sd0))
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (norm_x <= 16'sd16384 && norm_x >= -16'sd16384 &&
              norm_y <= 16'sd16384 && norm_y >= -16'sd16384 &&
              norm_z <= 16'sd16384 && norm_z >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind mesh_vertex_normals mvn_checker u_mvn_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .done(done),
  .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .degenerate(degenerate)
);
